### design/tnbw_pkg.sv
// Package for two_nearest_bone_weights: shared types, codes and constants.
// Used by the top level design/two_nearest_bone_weights.sv; depends on nothing else.
`timescale 1ns / 1ps

package tnbw_pkg;

  // field widths fixed by the interface
  localparam int COORD_W   = 16;
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int WEIGHT_W  = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 17;

  // distance arithmetic widths
  localparam int DIFF_W = COORD_W + 1;   // difference of two Q8.8 values
  localparam int SQ_W   = 32;            // square of a difference
  localparam int DIST_W = SQ_W + 2;      // sum of three squares
  localparam int SUM_W  = DIST_W + 1;    // d1 + d2
  localparam int REM_W  = SUM_W + 1;     // divider partial remainder

  // threshold reset value, 0.65 in Q0.16
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 17'd42598;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_FEW = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BONE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'd1;

  typedef struct packed {
    logic                      op;
    logic [SLOT_W-1:0]         bone_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } tnbw_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   nearest_bone;
    logic [SLOT_W-1:0]   second_bone;
    logic [WEIGHT_W-1:0] weight_near;
    logic [WEIGHT_W-1:0] weight_second;
    logic                status;
  } tnbw_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } joint_t;

  // one table entry: both joints of a bone
  typedef struct packed {
    joint_t joint_a;
    joint_t joint_b;
  } bone_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVIDE,
    ST_FINISH
  } tnbw_state_t;

endpackage

### design/two_nearest_bone_weights.sv
// A load word writes one table entry. A query word makes one table read per bone through a
// distance pipeline (read, difference, square, sum, nearer joint, running two nearest), then
// a restoring divider that makes one quotient bit a cycle.
// With fewer than two bones a query skips the scan and the divider; a stalled result waits.
// Reset clears control state, bone_count to 0 and separate_threshold to 0.65; the bone table
// is not cleared and holds nothing defined until loaded.
`timescale 1ns / 1ps

module two_nearest_bone_weights
  import tnbw_pkg::*;
#(
  parameter int MAX_BONES        = 64,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  tnbw_in_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output tnbw_out_t            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IW   = $clog2(MAX_BONES);
  localparam int CW   = $clog2(MAX_BONES + 1);
  localparam int QW   = WEIGHT_FRAC_BITS + 1;
  localparam int STW  = $clog2(WEIGHT_FRAC_BITS + 2);
  localparam int TW   = WEIGHT_FRAC_BITS + 33;
  localparam logic [QW-1:0]  ONE      = QW'(1) << WEIGHT_FRAC_BITS;
  localparam logic [STW-1:0] LAST_STEP = STW'(WEIGHT_FRAC_BITS);

  // configuration registers
  logic [COUNT_W-1:0] bone_count;
  logic [CFG_W-1:0]   separate_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count         <= '0;
      separate_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BONE_COUNT: bone_count         <= COUNT_W'(cfg_data);
        CFG_THRESHOLD:  separate_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective bone count, saturated to the table depth
  logic [CW-1:0] count_eff;
  logic          few_bones;

  always_comb begin
    if (32'(bone_count) > 32'(MAX_BONES)) begin
      count_eff = CW'(MAX_BONES);
    end else begin
      count_eff = CW'(bone_count);
    end
    few_bones = (32'(count_eff) < 32'd2);
  end

  // sequencer
  tnbw_state_t state, state_next;
  logic        req_take;
  logic        take_query;
  logic        take_load;
  logic        issue_en;
  logic        scan_done;
  logic        finish_load;

  logic [CW-1:0]  issue_cnt;
  logic [CW-1:0]  n_q;
  logic           few_q;
  logic [STW-1:0] step_cnt;

  // pipeline valids
  logic rd_v, df_v, sq_v, sm_v, mn_v;

  assign req_take   = req_valid && req_ready;
  assign take_query = req_take && (req.op == OP_QUERY);
  assign take_load  = req_take && (req.op == OP_LOAD);

  // fsm outputs
  always_comb begin
    req_ready   = (state == ST_IDLE);
    issue_en    = (state == ST_SCAN) && (issue_cnt < n_q);
    scan_done   = (state == ST_SCAN) && !(issue_cnt < n_q) &&
                  !rd_v && !df_v && !sq_v && !sm_v && !mn_v;
    finish_load = (state == ST_FINISH) && (!rsp_valid || rsp_ready);
  end

  // fsm next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_query) begin
          state_next = few_bones ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step_cnt == LAST_STEP) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // query setup and address issue
  joint_t vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      n_q       <= '0;
      few_q     <= 1'b0;
    end else if (take_query) begin
      issue_cnt <= '0;
      n_q       <= count_eff;
      few_q     <= few_bones;
    end else if (issue_en) begin
      issue_cnt <= issue_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_query) begin
      vertex <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z};
    end
  end

  // bone table, one write and one registered read a cycle
  bone_t          bone_mem [MAX_BONES];
  bone_t          rd_bone;
  logic [IW-1:0]  rd_idx;
  logic           load_ok;

  assign load_ok = take_load && (32'(req.bone_index) < 32'(MAX_BONES));

  always_ff @(posedge clk) begin
    if (load_ok) begin
      bone_mem[IW'(req.bone_index)] <= '{
        joint_a: '{x: req.pos_x, y: req.pos_y, z: req.pos_z},
        joint_b: '{x: req.end_x, y: req.end_y, z: req.end_z}};
    end
    if (issue_en) begin
      rd_bone <= bone_mem[IW'(issue_cnt)];
      rd_idx  <= IW'(issue_cnt);
    end
  end

  // valid bits travel with each bone through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      df_v <= 1'b0;
      sq_v <= 1'b0;
      sm_v <= 1'b0;
      mn_v <= 1'b0;
    end else begin
      rd_v <= issue_en;
      df_v <= rd_v;
      sq_v <= df_v;
      sm_v <= sq_v;
      mn_v <= sm_v;
    end
  end

  // six lanes: three axes of each joint
  logic signed [DIFF_W-1:0] diff_c [6];
  logic signed [DIFF_W-1:0] diff_q [6];
  logic [IW-1:0]            df_idx;

  function automatic logic signed [DIFF_W-1:0] sub_coord(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] bx;
    ax = {a[COORD_W-1], a};
    bx = {b[COORD_W-1], b};
    return ax - bx;
  endfunction

  always_comb begin
    diff_c[0] = sub_coord(vertex.x, rd_bone.joint_a.x);
    diff_c[1] = sub_coord(vertex.y, rd_bone.joint_a.y);
    diff_c[2] = sub_coord(vertex.z, rd_bone.joint_a.z);
    diff_c[3] = sub_coord(vertex.x, rd_bone.joint_b.x);
    diff_c[4] = sub_coord(vertex.y, rd_bone.joint_b.y);
    diff_c[5] = sub_coord(vertex.z, rd_bone.joint_b.z);
  end

  always_ff @(posedge clk) begin
    diff_q <= diff_c;
    df_idx <= rd_idx;
  end

  // squares, one multiplier per lane, operands sign-extended to the square width
  logic [SQ_W-1:0] sq_q [6];
  logic [IW-1:0]   sq_idx;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      sq_q[i] <= SQ_W'(SQ_W'(diff_q[i]) * SQ_W'(diff_q[i]));
    end
    sq_idx <= df_idx;
  end

  // distance to each joint
  logic [DIST_W-1:0] dist_a;
  logic [DIST_W-1:0] dist_b;
  logic [IW-1:0]     sm_idx;

  always_ff @(posedge clk) begin
    dist_a <= DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]);
    dist_b <= DIST_W'(sq_q[3]) + DIST_W'(sq_q[4]) + DIST_W'(sq_q[5]);
    sm_idx <= sq_idx;
  end

  // nearer joint
  logic [DIST_W-1:0] dist_min;
  logic [IW-1:0]     mn_idx;

  always_ff @(posedge clk) begin
    dist_min <= (dist_a < dist_b) ? dist_a : dist_b;
    mn_idx   <= sm_idx;
  end

  // running two nearest, lower index kept on a tie
  logic              have1, have2;
  logic [IW-1:0]     i1, i2;
  logic [DIST_W-1:0] d1, d2;

  always_ff @(posedge clk) begin
    if (rst || take_query) begin
      have1 <= 1'b0;
      have2 <= 1'b0;
      i1    <= '0;
      i2    <= '0;
      d1    <= '0;
      d2    <= '0;
    end else if (mn_v) begin
      if (!have1 || dist_min < d1) begin
        if (have1) begin
          i2    <= i1;
          d2    <= d1;
          have2 <= 1'b1;
        end
        i1    <= mn_idx;
        d1    <= dist_min;
        have1 <= 1'b1;
      end else if (!have2 || dist_min < d2) begin
        i2    <= mn_idx;
        d2    <= dist_min;
        have2 <= 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit a cycle: d2 * 2^frac / (d1 + d2)
  logic [SUM_W-1:0] div_sum;
  logic [REM_W-1:0] rem;
  logic [QW-1:0]    quot;
  logic             rem_ge;
  logic [REM_W-1:0] rem_sub;

  assign rem_ge  = (rem >= REM_W'(div_sum));
  assign rem_sub = rem - REM_W'(div_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (scan_done) begin
      step_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      div_sum <= SUM_W'(d1) + SUM_W'(d2);
      rem     <= REM_W'(d2);
      quot    <= '0;
    end else if (state == ST_DIVIDE) begin
      if (rem_ge) begin
        rem  <= rem_sub << 1;
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        rem  <= rem << 1;
        quot <= {quot[QW-2:0], 1'b0};
      end
    end
  end

  // final weights and threshold test
  logic [QW-1:0] wn_raw;
  logic [QW-1:0] ws_raw;
  logic [TW-1:0] wn_scaled;
  logic [TW-1:0] thr_scaled;
  tnbw_out_t     rsp_next;

  always_comb begin
    wn_raw     = (div_sum == '0) ? (ONE >> 1) : quot;
    ws_raw     = ONE - wn_raw;
    wn_scaled  = TW'(wn_raw) << 16;
    thr_scaled = TW'(separate_threshold) << WEIGHT_FRAC_BITS;
    if (wn_scaled > thr_scaled) begin
      wn_raw = ONE;
      ws_raw = '0;
    end
    if (few_q) begin
      rsp_next = '{nearest_bone: '0, second_bone: '0, weight_near: '0,
                   weight_second: '0, status: STATUS_FEW};
    end else begin
      rsp_next = '{nearest_bone:  SLOT_W'(i1),
                   second_bone:   SLOT_W'(i2),
                   weight_near:   WEIGHT_W'(wn_raw),
                   weight_second: WEIGHT_W'(ws_raw),
                   status:        STATUS_OK};
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

### tb/two_nearest_bone_weights_test.sv
// Testbench for two_nearest_bone_weights: loads bone joints, queries vertices and checks
// the nearest bone pair and blend weights against a scoreboard class with its own predictor.
// Depends on design/tnbw_pkg.sv and design/two_nearest_bone_weights.sv.
`timescale 1ns / 1ps

module two_nearest_bone_weights_test;
  import tnbw_pkg::*;

  localparam int NUM_SLOTS     = 64;
  localparam int FRAC_BITS     = 16;
  localparam int SETTLE_CYCLES = 120;
  localparam int PHASE_WORDS   = 210;
  localparam int NUM_PHASES    = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_MAX    = 10;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef longint unsigned dist_t;

  localparam coord_t COORD_MIN = 16'sh8000;
  localparam coord_t COORD_MAX = 16'sh7FFF;

  // predicts the bone pair and weights of each query and holds them until the response
  class blend_scoreboard;
    joint_t             start_joint[NUM_SLOTS];
    joint_t             end_joint[NUM_SLOTS];
    logic [COUNT_W-1:0] bone_count;
    logic [CFG_W-1:0]   threshold;
    tnbw_out_t          expected_blends[$];
    int                 mismatches;

    function new();
      bone_count = '0;
      threshold  = THRESHOLD_RESET;
      mismatches = 0;
      foreach (start_joint[k]) begin
        start_joint[k] = '0;
        end_joint[k]   = '0;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_BONE_COUNT) begin
        bone_count = data[COUNT_W-1:0];
      end else if (idx == CFG_THRESHOLD) begin
        threshold = data;
      end
    endfunction

    function dist_t joint_dist2(joint_t p, joint_t q);
      longint dx, dy, dz;
      dx = longint'($signed(p.x)) - longint'($signed(q.x));
      dy = longint'($signed(p.y)) - longint'($signed(q.y));
      dz = longint'($signed(p.z)) - longint'($signed(q.z));
      return dist_t'(dx * dx + dy * dy + dz * dz);
    endfunction

    function void note_word(tnbw_in_t w);
      joint_t    v;
      tnbw_out_t e;
      dist_t     a, b, d, d1, d2, sum, wn, ws;
      int        n, k, i1, i2;
      bit        have1, have2;
      if (w.op == OP_LOAD) begin
        start_joint[w.bone_index] = {w.pos_x, w.pos_y, w.pos_z};
        end_joint[w.bone_index]   = {w.end_x, w.end_y, w.end_z};
        return;
      end
      e = '0;
      n = (bone_count > NUM_SLOTS) ? NUM_SLOTS : int'(bone_count);
      if (n < 2) begin
        e.status = STATUS_FEW;
        expected_blends.insert(expected_blends.size(), e);
        return;
      end
      // scan for the two nearest bones, lower index wins a tie
      v = {w.pos_x, w.pos_y, w.pos_z};
      have1 = 0;
      have2 = 0;
      i1 = 0;
      i2 = 0;
      d1 = 0;
      d2 = 0;
      for (k = 0; k < n; k++) begin
        a = joint_dist2(v, start_joint[k]);
        b = joint_dist2(v, end_joint[k]);
        d = (a < b) ? a : b;
        if (!have1 || d < d1) begin
          if (have1) begin
            i2 = i1;
            d2 = d1;
            have2 = 1;
          end
          i1 = k;
          d1 = d;
          have1 = 1;
        end else if (!have2 || d < d2) begin
          i2 = k;
          d2 = d;
          have2 = 1;
        end
      end
      // blend weights, half each on a zero sum
      sum = d1 + d2;
      if (sum == 0) begin
        wn = dist_t'(1) << (FRAC_BITS - 1);
      end else begin
        wn = (d2 << FRAC_BITS) / sum;
      end
      ws = (dist_t'(1) << FRAC_BITS) - wn;
      // bind to one bone above the threshold
      if ((wn << 16) > (dist_t'(threshold) << FRAC_BITS)) begin
        wn = dist_t'(1) << FRAC_BITS;
        ws = 0;
      end
      e.nearest_bone  = i1[SLOT_W-1:0];
      e.second_bone   = i2[SLOT_W-1:0];
      e.weight_near   = wn[WEIGHT_W-1:0];
      e.weight_second = ws[WEIGHT_W-1:0];
      e.status        = STATUS_OK;
      expected_blends.insert(expected_blends.size(), e);
    endfunction

    function void complain(string what, tnbw_out_t e, tnbw_out_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t %s: expected near %0d second %0d weights %0d/%0d status %0d",
                 $time, what, e.nearest_bone, e.second_bone, e.weight_near,
                 e.weight_second, e.status);
        $display("    got near %0d second %0d weights %0d/%0d status %0d",
                 got.nearest_bone, got.second_bone, got.weight_near,
                 got.weight_second, got.status);
      end
    endfunction

    function void check_result(tnbw_out_t got);
      tnbw_out_t e;
      bit        bad;
      if (expected_blends.size() == 0) begin
        complain("response with no query waiting", '0, got);
        return;
      end
      e = expected_blends.pop_front();
      bad = (got.nearest_bone !== e.nearest_bone) || (got.second_bone !== e.second_bone) ||
            (got.weight_near !== e.weight_near) || (got.weight_second !== e.weight_second) ||
            (got.status !== e.status);
      if (bad) begin
        complain("response mismatch", e, got);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  tnbw_in_t             req;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  tnbw_out_t            rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  blend_scoreboard      board;
  int                   send_idle;
  int                   recv_stall;
  int unsigned          cycles = 0;
  logic [NUM_SLOTS-1:0] loaded;

  two_nearest_bone_weights u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** two_nearest_bone_weights: FAILED **");
      $finish;
    end
  end

  // response side: check each accepted word, stall at random
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      board.check_result(rsp);
    end
    rsp_ready <= ($urandom_range(99) >= recv_stall);
  end

  // present one word, with a random gap before it, and hold it until accepted
  task automatic send_word(tnbw_in_t w);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (!req_ready);
    board.note_word(w);
    if (w.op == OP_LOAD) begin
      loaded[w.bone_index] = 1'b1;
    end
  endtask

  // stop sending, wait for every response, then let a query in flight finish
  task automatic settle();
    req_valid <= 1'b0;
    while (board.expected_blends.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3, 4, 5: return coord_t'($urandom);
      default: return coord_t'($urandom_range(1023)) - coord_t'(512);
    endcase
  endfunction

  function automatic coord_t near_coord(coord_t c);
    return c + coord_t'($urandom_range(63)) - coord_t'(32);
  endfunction

  function automatic tnbw_in_t bone_word(int slot, coord_t sx, coord_t sy, coord_t sz,
                                         coord_t ex, coord_t ey, coord_t ez);
    tnbw_in_t w;
    w.op         = OP_LOAD;
    w.bone_index = slot[SLOT_W-1:0];
    {w.pos_x, w.pos_y, w.pos_z} = {sx, sy, sz};
    {w.end_x, w.end_y, w.end_z} = {ex, ey, ez};
    return w;
  endfunction

  // unused fields of a query carry random bits
  function automatic tnbw_in_t vertex_word(coord_t x, coord_t y, coord_t z);
    tnbw_in_t w;
    w.op         = OP_QUERY;
    w.bone_index = SLOT_W'($urandom_range(NUM_SLOTS - 1));
    {w.pos_x, w.pos_y, w.pos_z} = {x, y, z};
    {w.end_x, w.end_y, w.end_z} = {pick_coord(), pick_coord(), pick_coord()};
    return w;
  endfunction

  // random word for n bones in use; a query never reads a slot not yet loaded
  function automatic tnbw_in_t random_word(int n);
    tnbw_in_t w;
    joint_t   j;
    int       k, gap;
    w.op         = ($urandom_range(99) < 65) ? OP_QUERY : OP_LOAD;
    w.bone_index = SLOT_W'($urandom_range(NUM_SLOTS - 1));
    {w.pos_x, w.pos_y, w.pos_z} = {pick_coord(), pick_coord(), pick_coord()};
    {w.end_x, w.end_y, w.end_z} = {pick_coord(), pick_coord(), pick_coord()};
    gap = -1;
    for (k = n - 1; k >= 0; k--) begin
      if (!loaded[k]) gap = k;
    end
    if (w.op == OP_QUERY && n >= 2 && gap >= 0) begin
      w.op         = OP_LOAD;
      w.bone_index = gap[SLOT_W-1:0];
    end
    if (w.op == OP_LOAD) begin
      // mostly slots that queries look at
      if (n >= 2 && gap < 0 && $urandom_range(99) < 75) begin
        w.bone_index = SLOT_W'($urandom_range(n - 1));
      end
      // copy another bone to make equal distances
      if ($urandom_range(99) < 15) begin
        k = $urandom_range(NUM_SLOTS - 1);
        if (loaded[k]) begin
          {w.pos_x, w.pos_y, w.pos_z} = board.start_joint[k];
          {w.end_x, w.end_y, w.end_z} = board.end_joint[k];
        end
      end
    end else if (n >= 2 && $urandom_range(99) < 70) begin
      // vertex on or close to a joint in use
      k = $urandom_range(n - 1);
      j = $urandom_range(1) ? board.start_joint[k] : board.end_joint[k];
      if ($urandom_range(3) == 0) begin
        {w.pos_x, w.pos_y, w.pos_z} = j;
      end else begin
        w.pos_x = near_coord(j.x);
        w.pos_y = near_coord(j.y);
        w.pos_z = near_coord(j.z);
      end
    end
    return w;
  endfunction

  // stimulus
  initial begin
    int               p, i, n, count_cfg;
    logic [CFG_W-1:0] thr_cfg;
    board      = new();
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    send_idle  = 0;
    recv_stall = 0;
    loaded     = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // too few bones, at the reset count and at one
    send_word(vertex_word(100, -100, 7));
    settle();
    write_register(CFG_BONE_COUNT, 1);
    send_word(vertex_word(-1, 0, 1));

    // extreme joints
    send_word(bone_word(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_word(bone_word(1, 0, 0, 0, 256, 256, 256));
    settle();
    write_register(CFG_BONE_COUNT, 2);
    send_word(vertex_word(COORD_MIN, COORD_MIN, COORD_MIN));
    send_word(vertex_word(COORD_MAX, COORD_MAX, COORD_MAX));
    send_word(vertex_word(COORD_MIN, COORD_MAX, COORD_MIN));
    send_word(vertex_word(128, 128, 128));
    send_word(vertex_word(300, -5, 77));

    // identical bones: zero sum and equal distances
    send_word(bone_word(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_word(vertex_word(COORD_MIN, COORD_MIN, COORD_MIN));
    send_word(vertex_word(0, 0, 0));

    // threshold at both ends
    send_word(bone_word(1, 0, 0, 0, 256, 256, 256));
    settle();
    write_register(CFG_THRESHOLD, 17'd0);
    send_word(vertex_word(64, 64, 64));
    send_word(vertex_word(0, 0, 0));
    settle();
    write_register(CFG_THRESHOLD, 17'd65536);
    send_word(vertex_word(64, 64, 64));
    send_word(vertex_word(COORD_MIN, COORD_MIN, COORD_MIN));

    // weight exactly at the threshold, then one below it
    send_word(bone_word(0, -256, 0, 0, -256, 0, 0));
    send_word(bone_word(1, 256, 0, 0, 256, 0, 0));
    settle();
    write_register(CFG_THRESHOLD, 17'd32768);
    send_word(vertex_word(0, 0, 0));
    settle();
    write_register(CFG_THRESHOLD, 17'd32767);
    send_word(vertex_word(0, 0, 0));

    // random phases, each with its own settings and idling
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin count_cfg = 2;   thr_cfg = THRESHOLD_RESET;         end
        1: begin count_cfg = 4;   thr_cfg = 17'd0;                   end
        2: begin count_cfg = 64;  thr_cfg = 17'd65536;               end
        3: begin count_cfg = 127; thr_cfg = CFG_W'($urandom_range(131071)); end
        4: begin count_cfg = 1;   thr_cfg = 17'd32768;               end
        5: begin count_cfg = 3;   thr_cfg = 17'd65535;               end
        6: begin
          count_cfg = $urandom_range(24, 5);
          thr_cfg   = CFG_W'($urandom_range(65536));
        end
        default: begin count_cfg = 8; thr_cfg = 17'd1;               end
      endcase
      write_register(CFG_BONE_COUNT, CFG_W'(count_cfg));
      write_register(CFG_THRESHOLD, thr_cfg);
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 45; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 45; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      n = (count_cfg > NUM_SLOTS) ? NUM_SLOTS : count_cfg;
      for (i = 0; i < PHASE_WORDS; i++) begin
        send_word(random_word(n));
      end
    end

    settle();
    if (board.expected_blends.size() != 0) begin
      $display("%0d query responses never arrived", board.expected_blends.size());
    end
    if (board.mismatches == 0 && board.expected_blends.size() == 0) begin
      $display("** two_nearest_bone_weights: PASSED **");
    end else begin
      $display("** two_nearest_bone_weights: FAILED **");
    end
    $finish;
  end

endmodule
